// ===== sv/nzp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nested zone tick profiler package
// Shared constants, payload types, frame layout and the control interface
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package nzp_pkg;

    // Sizing of the anchor tables and the zone stack.
    localparam int NUM_ANCHORS = 1024;
    localparam int STACK_DEPTH = 32;

    // Fixed field widths.
    localparam int KIND_W   = 2;
    localparam int ANCHOR_W = 10;
    localparam int TICK_W   = 64;
    localparam int STATUS_W = 2;

    // Derived widths.
    localparam int ANC_W = $clog2(NUM_ANCHORS);
    localparam int SP_W  = $clog2(STACK_DEPTH);
    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int NUM_W = $clog2(NUM_ANCHORS + 1);

    // Anchor folding by reciprocal multiplication: the estimate is at most
    // one below the true quotient, so a single correction step suffices.
    localparam int FOLD_SH    = 2 * ANCHOR_W;
    localparam int FOLD_PW    = ANCHOR_W + FOLD_SH;
    localparam int FOLD_RECIP = (2 ** FOLD_SH) / NUM_ANCHORS;
    localparam int FOLD_MW    = ANCHOR_W + NUM_W;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_START = KIND_W'(0);
    localparam logic [KIND_W-1:0] KIND_END   = KIND_W'(1);
    localparam logic [KIND_W-1:0] KIND_READ  = KIND_W'(2);

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK        = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = STATUS_W'(2);

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [ANCHOR_W-1:0] anchor;
        logic [TICK_W-1:0]   timestamp;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TICK_W-1:0]   incl_ticks;
        logic [TICK_W-1:0]   excl_ticks;
        logic [TICK_W-1:0]   zone_hits;
    } out_item_t;

    typedef struct packed {
        logic [ANC_W-1:0]  parent;
        logic [ANC_W-1:0]  anchor;
        logic [TICK_W-1:0] old_total;
        logic [TICK_W-1:0] start;
    } frame_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ARD,
        S_AOUT,
        S_POP,
        S_ERD,
        S_EWR1,
        S_EWR2,
        S_ZOUT
    } state_t;

    typedef enum logic [2:0] {
        OP_START,
        OP_OVFL,
        OP_READ,
        OP_END,
        OP_UNDER,
        OP_NONE
    } op_t;

    typedef enum logic [1:0] {
        OSRC_READ,
        OSRC_UPD,
        OSRC_ZERO
    } out_src_t;

    typedef struct packed {
        logic                load_in;
        logic                clr_en;
        logic                anc_rd;
        logic                push;
        logic                pop_rd;
        logic                end_rd;
        logic                end_wr1;
        logic                end_wr2;
        logic                out_load;
        out_src_t            out_src;
        logic [STATUS_W-1:0] out_status;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic stack_full;
        logic stack_empty;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== sv/nzp_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nested zone tick profiler controller
// Sequences table clearing, item decode and the read and write passes.
// ----------------------------------------------------------------------------
module nzp_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic [nzp_pkg::KIND_W-1:0] s_kind,
    output logic                     s_ready,
    input  nzp_pkg::dp_stat_t        stat,
    output nzp_pkg::ctrl_cmd_t       cmd
);
    import nzp_pkg::*;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            op_reg    <= OP_NONE;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        s_ready        = 1'b0;
        cmd            = '0;
        cmd.out_src    = OSRC_ZERO;
        cmd.out_status = STATUS_OK;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_en = 1'b1;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    priority if (s_kind == KIND_START) begin
                        op_next    = stat.stack_full ? OP_OVFL : OP_START;
                        state_next = S_ARD;
                    end else if (s_kind == KIND_END) begin
                        op_next    = stat.stack_empty ? OP_UNDER : OP_END;
                        state_next = stat.stack_empty ? S_ZOUT : S_POP;
                    end else if (s_kind == KIND_READ) begin
                        op_next    = OP_READ;
                        state_next = S_ARD;
                    end else begin
                        op_next    = OP_NONE;
                        state_next = S_ZOUT;
                    end
                end
            end
            S_ARD: begin
                cmd.anc_rd = 1'b1;
                state_next = S_AOUT;
            end
            S_AOUT: begin
                if (stat.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_src    = OSRC_READ;
                    cmd.out_status = (op_reg == OP_OVFL) ? STATUS_OVERFLOW : STATUS_OK;
                    cmd.push       = (op_reg == OP_START);
                    state_next     = S_IDLE;
                end
            end
            S_POP: begin
                cmd.pop_rd = 1'b1;
                state_next = S_ERD;
            end
            S_ERD: begin
                cmd.end_rd = 1'b1;
                state_next = S_EWR1;
            end
            S_EWR1: begin
                cmd.end_wr1 = 1'b1;
                state_next  = S_EWR2;
            end
            S_EWR2: begin
                if (stat.out_free) begin
                    cmd.end_wr2  = 1'b1;
                    cmd.out_load = 1'b1;
                    cmd.out_src  = OSRC_UPD;
                    state_next   = S_IDLE;
                end
            end
            S_ZOUT: begin
                if (stat.out_free) begin
                    cmd.out_load   = 1'b1;
                    cmd.out_src    = OSRC_ZERO;
                    cmd.out_status = (op_reg == OP_UNDER) ? STATUS_UNDERFLOW : STATUS_OK;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== sv/nzp_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nested zone tick profiler datapath
// Anchor counter memories, zone frame stack, arithmetic and result register.
// ----------------------------------------------------------------------------
module nzp_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  nzp_pkg::in_item_t   s_data,
    input  nzp_pkg::ctrl_cmd_t  cmd,
    output nzp_pkg::dp_stat_t   stat,
    output logic                m_valid,
    input  logic                m_ready,
    output nzp_pkg::out_item_t  m_data
);
    import nzp_pkg::*;

    // Captured input item.
    logic [ANCHOR_W-1:0] raw_reg;
    logic [ANCHOR_W-1:0] quot_reg;
    logic [TICK_W-1:0]   ts_reg;

    // Control state kept in the datapath.
    logic [ANC_W-1:0] clr_addr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [ANC_W-1:0] cur_parent_reg;
    logic             m_valid_reg;

    // Memories and their registered read data.
    logic [TICK_W-1:0] total_mem [NUM_ANCHORS];
    logic [TICK_W-1:0] self_mem  [NUM_ANCHORS];
    logic [TICK_W-1:0] hits_mem  [NUM_ANCHORS];
    frame_t            stack_mem [STACK_DEPTH];

    logic [TICK_W-1:0] total_rd_reg;
    logic [TICK_W-1:0] self_anc_rd_reg;
    logic [TICK_W-1:0] self_par_rd_reg;
    logic [TICK_W-1:0] hits_rd_reg;
    frame_t            frame_rd_reg;

    // Zone end working registers.
    logic [TICK_W-1:0] elapsed_reg;
    logic [TICK_W-1:0] upd_total_reg;
    logic [TICK_W-1:0] upd_self_reg;
    logic [TICK_W-1:0] upd_hits_reg;

    out_item_t out_reg;

    // Anchor folding.
    logic [FOLD_PW-1:0]  quot_prod;
    logic [FOLD_MW-1:0]  back_prod;
    logic [ANCHOR_W-1:0] rem0;
    logic [ANCHOR_W-1:0] rem1;
    logic [ANC_W-1:0]    idx;

    // Memory port selection.
    logic [ANC_W-1:0]  self_raddr;
    logic [ANC_W-1:0]  hits_raddr;
    logic              self_we;
    logic [ANC_W-1:0]  self_waddr;
    logic [TICK_W-1:0] self_wdata;
    logic              anc_we;
    logic [ANC_W-1:0]  anc_waddr;
    logic [TICK_W-1:0] total_wdata;
    logic [TICK_W-1:0] hits_wdata;
    logic [SP_W-1:0]   push_addr;
    logic [SP_W-1:0]   pop_addr;
    logic [CNT_W-1:0]  count_dec;
    frame_t            push_frame;

    assign quot_prod = FOLD_PW'(s_data.anchor) * FOLD_PW'(FOLD_RECIP);
    assign back_prod = FOLD_MW'(quot_reg) * FOLD_MW'(NUM_ANCHORS);
    assign rem0      = raw_reg - back_prod[ANCHOR_W-1:0];
    assign rem1      = (FOLD_MW'(rem0) >= FOLD_MW'(NUM_ANCHORS))
                     ? rem0 - ANCHOR_W'(NUM_ANCHORS) : rem0;
    assign idx       = ANC_W'(rem1);

    assign count_dec  = count_reg - CNT_W'(1);
    assign push_addr  = count_reg[SP_W-1:0];
    assign pop_addr   = count_dec[SP_W-1:0];
    assign push_frame = '{parent: cur_parent_reg, anchor: idx,
                          old_total: total_rd_reg, start: ts_reg};

    assign self_raddr = cmd.anc_rd ? idx : frame_rd_reg.anchor;
    assign hits_raddr = cmd.anc_rd ? idx : frame_rd_reg.anchor;

    always_comb begin
        self_we     = cmd.clr_en | cmd.end_wr1 | cmd.end_wr2;
        anc_we      = cmd.clr_en | cmd.end_wr2;
        self_waddr  = clr_addr_reg;
        anc_waddr   = clr_addr_reg;
        self_wdata  = '0;
        total_wdata = '0;
        hits_wdata  = '0;
        if (cmd.end_wr1) begin
            self_waddr = frame_rd_reg.parent;
            self_wdata = self_par_rd_reg - elapsed_reg;
        end else if (cmd.end_wr2) begin
            self_waddr  = frame_rd_reg.anchor;
            self_wdata  = upd_self_reg;
            anc_waddr   = frame_rd_reg.anchor;
            total_wdata = upd_total_reg;
            hits_wdata  = upd_hits_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (anc_we) begin
            total_mem[anc_waddr] <= total_wdata;
        end
        if (cmd.anc_rd) begin
            total_rd_reg <= total_mem[idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (self_we) begin
            self_mem[self_waddr] <= self_wdata;
        end
        if (cmd.anc_rd || cmd.end_rd) begin
            self_anc_rd_reg <= self_mem[self_raddr];
        end
        if (cmd.end_rd) begin
            self_par_rd_reg <= self_mem[frame_rd_reg.parent];
        end
    end

    always_ff @(posedge aclk) begin
        if (anc_we) begin
            hits_mem[anc_waddr] <= hits_wdata;
        end
        if (cmd.anc_rd || cmd.end_rd) begin
            hits_rd_reg <= hits_mem[hits_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            stack_mem[push_addr] <= push_frame;
        end
        if (cmd.pop_rd) begin
            frame_rd_reg <= stack_mem[pop_addr];
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            raw_reg  <= s_data.anchor;
            quot_reg <= quot_prod[FOLD_SH +: ANCHOR_W];
            ts_reg   <= s_data.timestamp;
        end
        if (cmd.end_rd) begin
            elapsed_reg <= ts_reg - frame_rd_reg.start;
        end
        if (cmd.end_wr1) begin
            // When a zone nests inside itself, the parent's loss and the
            // anchor's gain cancel on the same entry.
            upd_self_reg  <= (frame_rd_reg.parent == frame_rd_reg.anchor)
                           ? self_anc_rd_reg : self_anc_rd_reg + elapsed_reg;
            upd_total_reg <= frame_rd_reg.old_total + elapsed_reg;
            upd_hits_reg  <= hits_rd_reg + TICK_W'(1);
        end
        if (cmd.out_load) begin
            out_reg.status <= cmd.out_status;
            unique case (cmd.out_src)
                OSRC_READ: begin
                    out_reg.incl_ticks <= total_rd_reg;
                    out_reg.excl_ticks <= self_anc_rd_reg;
                    out_reg.zone_hits  <= hits_rd_reg;
                end
                OSRC_UPD: begin
                    out_reg.incl_ticks <= upd_total_reg;
                    out_reg.excl_ticks <= upd_self_reg;
                    out_reg.zone_hits  <= upd_hits_reg;
                end
                default: begin
                    out_reg.incl_ticks <= '0;
                    out_reg.excl_ticks <= '0;
                    out_reg.zone_hits  <= '0;
                end
            endcase
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg   <= '0;
            count_reg      <= '0;
            cur_parent_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.clr_en) begin
                clr_addr_reg <= clr_addr_reg + ANC_W'(1);
            end
            if (cmd.push) begin
                count_reg      <= count_reg + CNT_W'(1);
                cur_parent_reg <= idx;
            end else if (cmd.pop_rd) begin
                count_reg <= count_dec;
            end
            if (cmd.end_wr1) begin
                cur_parent_reg <= frame_rd_reg.parent;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.clr_last    = (clr_addr_reg == ANC_W'(NUM_ANCHORS - 1));
    assign stat.stack_full  = (count_reg == CNT_W'(STACK_DEPTH));
    assign stat.stack_empty = (count_reg == '0);
    assign stat.out_free    = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== sv/nested_zone_tick_profiler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nested zone tick profiler
// Hierarchical profiler keeping inclusive and exclusive tick counts and hit
// counts per anchor, driven by zone start, zone end and read events.
// ----------------------------------------------------------------------------
// After reset the block clears its three anchor counter tables, one entry per
// cycle, and holds s_ready low until the last entry is cleared before it takes
// its first transfer. Items are handled one at a time by a controller that
// walks a datapath through table read and write passes. A zone start or a
// read steps through accept, table read and result load; a zone end steps
// through accept, frame pop, table read, parent update and anchor update with
// result load, because the parent's and the anchor's self counters share one
// write port; an end on an empty stack and an unused kind step through accept
// and result load. Each item yields exactly one result transfer. The result
// sits in an output register, so the next item is taken while that result
// still waits; the block stalls only if a second result is ready before the
// first has been taken. Counters wrap modulo 2^64, an anchor index beyond the
// table folds modulo NUM_ANCHORS, a start on a full stack reports overflow and
// changes nothing, and an end on an empty stack reports underflow with zero
// counters. Ends always pop the top frame.
// ----------------------------------------------------------------------------
module nested_zone_tick_profiler_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  nzp_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output nzp_pkg::out_item_t m_data
);
    import nzp_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // The controller decodes the item kind at acceptance and issues one
    // command set per cycle; the datapath reports stack and output status.
    nzp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_data.kind),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // The datapath owns the counter tables, the frame stack, the current
    // parent and the result register.
    nzp_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== sv/nzp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nested zone tick profiler checker
// Port-level assertions on the profiler, bound to the top level.
// ----------------------------------------------------------------------------
module nzp_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input nzp_pkg::in_item_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input nzp_pkg::out_item_t m_data
);
    import nzp_pkg::*;

    // A result that is not taken stays offered and unchanged.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // Reset empties the result register and starts the table clearing.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("block not quiet after reset");

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transfer accepted back to back");

    // An underflow result carries no counters.
    a_underflow_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == STATUS_UNDERFLOW |->
            m_data.incl_ticks == '0 && m_data.excl_ticks == '0
            && m_data.zone_hits == '0)
        else $error("underflow result with nonzero counters");

    // An offered result always carries one of the defined status codes.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.status == STATUS_OK || m_data.status == STATUS_OVERFLOW
            || m_data.status == STATUS_UNDERFLOW)
        else $error("result status outside defined codes");

endmodule

bind nested_zone_tick_profiler_top nzp_checker u_nzp_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
